// ===== hw/rtl/neighbor_table_with_aging_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Neighbour table assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef NEIGHBOR_TABLE_WITH_AGING_UNIT_MACROS_SVH
`define NEIGHBOR_TABLE_WITH_AGING_UNIT_MACROS_SVH

// Same-cycle implication, reset masks the check
`define NTA_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masks the check
`define NTA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/nta_pkg.sv =====
// ----------------------------------------------------------------------------
// Neighbour table package
// Field widths, operation and status codes, register map and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package nta_pkg;

    localparam int unsigned ADDR_W        = 64;
    localparam int unsigned FLEN_W        = 16;
    localparam int unsigned TIME_W        = 32;
    localparam int unsigned OP_W          = 2;
    localparam int unsigned STATUS_W      = 4;
    localparam int unsigned SLOT_FIELD_W  = 3;
    localparam int unsigned EXP_FIELD_W   = 4;
    localparam int unsigned LIMIT_W       = 4;
    localparam int unsigned CFG_IDX_W     = 3;
    localparam int unsigned CFG_DATA_W    = 32;
    localparam int unsigned IN_TDATA_W    = 176;
    localparam int unsigned IN_TUSER_W    = 2;
    localparam int unsigned OUT_TDATA_W   = 144;
    localparam int unsigned OUT_TUSER_W   = 4;
    localparam int unsigned OUT_PAD_W     = 7;

    // Operations
    localparam logic [OP_W-1:0] OP_BEACON = 2'd0;
    localparam logic [OP_W-1:0] OP_DATA   = 2'd1;
    localparam logic [OP_W-1:0] OP_ECHO   = 2'd2;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_ADDED     = 4'd0;
    localparam logic [STATUS_W-1:0] ST_REFRESHED = 4'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 4'd2;
    localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 4'd3;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 4'd4;
    localparam logic [STATUS_W-1:0] ST_OVERSIZE  = 4'd5;
    localparam logic [STATUS_W-1:0] ST_REVERSE   = 4'd6;
    localparam logic [STATUS_W-1:0] ST_TICK      = 4'd7;
    localparam logic [STATUS_W-1:0] ST_ECHO      = 4'd8;

    // Register map
    localparam logic [CFG_IDX_W-1:0] CFG_PEER_LIMIT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPIRY       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_TIMEOUT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOPBACK     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME    = 3'd5;

    // Register reset values
    localparam logic [LIMIT_W-1:0] RST_PEER_LIMIT   = 4'd8;
    localparam logic [TIME_W-1:0]  RST_EXPIRY       = 32'd22000;
    localparam logic [TIME_W-1:0]  RST_REVERSE      = 32'd5200;
    localparam logic [TIME_W-1:0]  RST_ECHO_TIMEOUT = 32'd6500;
    localparam logic               RST_LOOPBACK     = 1'b1;
    localparam logic [FLEN_W-1:0]  RST_MAX_FRAME    = 16'd500;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              is_lookup;
        logic [ADDR_W-1:0] addr_high;
        logic [ADDR_W-1:0] addr_low;
        logic [FLEN_W-1:0] frame_length;
        logic [TIME_W-1:0] now_ms;
    } item_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] peer_limit;
        logic [TIME_W-1:0]  expiry_ms;
        logic [TIME_W-1:0]  reverse_interval_ms;
        logic [TIME_W-1:0]  echo_timeout_ms;
        logic               loopback_ok;
        logic [FLEN_W-1:0]  max_frame_len;
    } cfg_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [ADDR_W-1:0]      peer_high;
        logic [ADDR_W-1:0]      peer_low;
        logic [EXP_FIELD_W-1:0] expired_count;
        logic                   carrier_ok;
        logic                   carrier_changed;
        logic                   last;
    } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/nta_front.sv =====
// ----------------------------------------------------------------------------
// Neighbour table front end
// Accept input transactions, tag table lookups and hold them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module nta_front
    import nta_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
    input  wire logic [IN_TUSER_W-1:0] s_axis_tuser,
    output logic                       q_valid,
    input  wire logic                  q_pop,
    output item_t                      q_item
);

    localparam int unsigned QUEUE_DEPTH = 2;

    item_t            entry_reg [QUEUE_DEPTH];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             push;
    item_t            in_item;

    // Unpack and classify
    always_comb
    begin
        in_item.op           = s_axis_tuser;
        in_item.is_lookup    = (s_axis_tuser == OP_BEACON) || (s_axis_tuser == OP_DATA);
        in_item.addr_high    = s_axis_tdata[63:0];
        in_item.addr_low     = s_axis_tdata[127:64];
        in_item.frame_length = s_axis_tdata[143:128];
        in_item.now_ms       = s_axis_tdata[175:144];
    end

    assign s_axis_tready = (count_reg != 2'(QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (count_reg != 2'd0);
    assign q_item        = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (q_pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        case ({push, q_pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/nta_back.sv =====
// ----------------------------------------------------------------------------
// Neighbour table back end: update the table and drive the result register.
// Walk the peer table one slot a cycle, held while a reverse result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module nta_back
    import nta_pkg::*;
#(
    parameter int unsigned TABLE_SLOTS = 8
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  q_valid,
    output logic       q_pop,
    input  wire item_t q_item,
    output logic       res_valid,
    input  wire logic  res_ready,
    output res_t       res
);

    localparam int unsigned SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int unsigned CNT_W  = $clog2(TABLE_SLOTS + 1);
    localparam int unsigned CMP_W  = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int unsigned SXW    = (SLOT_W > SLOT_FIELD_W) ? SLOT_W : SLOT_FIELD_W;
    localparam int unsigned XW     = (CNT_W > EXP_FIELD_W) ? CNT_W : EXP_FIELD_W;
    localparam logic [CNT_W-1:0] SLOT_COUNT = CNT_W'(TABLE_SLOTS);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CARR   = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    // Table memories, entries undefined until written
    logic [2*ADDR_W-1:0] addr_mem  [TABLE_SLOTS];
    logic [TIME_W-1:0]   heard_mem [TABLE_SLOTS];
    logic [TIME_W-1:0]   rev_mem   [TABLE_SLOTS];
    logic [2*ADDR_W-1:0] rd_addr_reg;
    logic [TIME_W-1:0]   rd_heard_reg;
    logic [TIME_W-1:0]   rd_rev_reg;

    logic [1:0]             state_reg, state_next;
    item_t                  cur_reg, cur_next;
    logic [CNT_W-1:0]       rd_cnt_reg, rd_cnt_next;
    logic                   ev_v_reg, ev_v_next;
    logic [SLOT_W-1:0]      ev_idx_reg, ev_idx_next;
    logic                   found_reg, found_next;
    logic [SLOT_W-1:0]      found_idx_reg, found_idx_next;
    logic                   free_found_reg, free_found_next;
    logic [SLOT_W-1:0]      free_idx_reg, free_idx_next;
    logic [CNT_W-1:0]       used_reg, used_next;
    logic [CNT_W-1:0]       expired_reg, expired_next;
    logic                   changed_reg, changed_next;
    logic [TABLE_SLOTS-1:0] valid_reg, valid_next;
    logic [TIME_W-1:0]      echo_time_reg, echo_time_next;
    logic                   echo_seen_reg, echo_seen_next;
    logic [TIME_W-1:0]      rx_time_reg, rx_time_next;
    logic                   rx_seen_reg, rx_seen_next;
    logic                   carrier_reg, carrier_next;
    logic                   out_valid_reg, out_valid_next;
    res_t                   out_reg, out_next;

    logic                   out_free;
    logic                   out_load;
    logic                   adv;
    logic                   rd_en;
    logic [SLOT_W-1:0]      rd_idx;
    logic                   addr_we, heard_we, rev_we;
    logic [SLOT_W-1:0]      wr_idx;
    logic                   ev_valid, ev_match, ev_expire, ev_due;
    logic [TIME_W-1:0]      heard_age, rev_age, echo_age, rx_age;
    logic                   echo_ok, rx_ok, carrier_ok;
    logic [CMP_W-1:0]       limit_x;
    logic [SXW-1:0]         ev_slot_x, found_slot_x, free_slot_x;
    logic [XW-1:0]          expired_x;

    assign rd_idx       = rd_cnt_reg[SLOT_W-1:0];
    assign out_free     = !out_valid_reg || res_ready;
    assign ev_valid     = valid_reg[ev_idx_reg];
    assign ev_match     = ev_valid && (rd_addr_reg == {cur_reg.addr_high, cur_reg.addr_low});
    assign heard_age    = cur_reg.now_ms - rd_heard_reg;
    assign rev_age      = cur_reg.now_ms - rd_rev_reg;
    assign ev_expire    = ev_valid && (heard_age > cfg.expiry_ms);
    assign ev_due       = ev_valid && !ev_expire && (rev_age >= cfg.reverse_interval_ms);
    assign echo_age     = cur_reg.now_ms - echo_time_reg;
    assign rx_age       = cur_reg.now_ms - rx_time_reg;
    assign echo_ok      = echo_seen_reg && (echo_age <= cfg.echo_timeout_ms);
    assign rx_ok        = rx_seen_reg && (rx_age <= cfg.echo_timeout_ms);
    assign carrier_ok   = cfg.loopback_ok ? (echo_ok || rx_ok) : rx_ok;
    // Zero limit behaves as one
    assign limit_x      = (cfg.peer_limit == '0) ? CMP_W'(1) : CMP_W'(cfg.peer_limit);
    assign ev_slot_x    = SXW'(ev_idx_reg);
    assign found_slot_x = SXW'(found_idx_reg);
    assign free_slot_x  = SXW'(free_idx_reg);
    assign expired_x    = XW'(expired_reg);

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        rd_cnt_next     = rd_cnt_reg;
        ev_v_next       = ev_v_reg;
        ev_idx_next     = ev_idx_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        used_next       = used_reg;
        expired_next    = expired_reg;
        changed_next    = changed_reg;
        valid_next      = valid_reg;
        echo_time_next  = echo_time_reg;
        echo_seen_next  = echo_seen_reg;
        rx_time_next    = rx_time_reg;
        rx_seen_next    = rx_seen_reg;
        carrier_next    = carrier_reg;
        q_pop           = 1'b0;
        adv             = 1'b1;
        rd_en           = 1'b0;
        addr_we         = 1'b0;
        heard_we        = 1'b0;
        rev_we          = 1'b0;
        wr_idx          = ev_idx_reg;
        out_load        = 1'b0;
        out_next        = out_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop           = 1'b1;
                    cur_next        = q_item;
                    rd_cnt_next     = '0;
                    ev_v_next       = 1'b0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    used_next       = '0;
                    expired_next    = '0;
                    if (q_item.is_lookup)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (q_item.op == OP_TICK)
                    begin
                        state_next = S_CARR;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
            end

            S_CARR:
            begin
                // Carrier moves before any reverse result of this tick
                changed_next = (carrier_ok != carrier_reg);
                carrier_next = carrier_ok;
                state_next   = S_SCAN;
            end

            S_SCAN:
            begin
                if (ev_v_reg && !cur_reg.is_lookup && ev_due && !out_free)
                begin
                    adv = 1'b0;
                end
                if (ev_v_reg && adv)
                begin
                    if (cur_reg.is_lookup)
                    begin
                        if (ev_match && !found_reg)
                        begin
                            found_next     = 1'b1;
                            found_idx_next = ev_idx_reg;
                        end
                        if (ev_valid)
                        begin
                            used_next = used_reg + CNT_W'(1);
                        end
                        else if (!free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = ev_idx_reg;
                        end
                    end
                    else if (ev_expire)
                    begin
                        valid_next[ev_idx_reg] = 1'b0;
                        expired_next           = expired_reg + CNT_W'(1);
                    end
                    else if (ev_due)
                    begin
                        rev_we                   = 1'b1;
                        wr_idx                   = ev_idx_reg;
                        out_load                 = 1'b1;
                        out_next                 = '0;
                        out_next.status          = ST_REVERSE;
                        out_next.slot            = ev_slot_x[SLOT_FIELD_W-1:0];
                        out_next.peer_high       = rd_addr_reg[2*ADDR_W-1:ADDR_W];
                        out_next.peer_low        = rd_addr_reg[ADDR_W-1:0];
                        out_next.carrier_ok      = carrier_reg;
                        out_next.last            = 1'b0;
                    end
                end
                if (adv)
                begin
                    if (rd_cnt_reg < SLOT_COUNT)
                    begin
                        rd_en       = 1'b1;
                        rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                        ev_v_next   = 1'b1;
                        ev_idx_next = rd_idx;
                    end
                    else
                    begin
                        ev_v_next  = 1'b0;
                        state_next = S_RESULT;
                    end
                end
            end

            S_RESULT:
            begin
                if (out_free)
                begin
                    out_load            = 1'b1;
                    out_next            = '0;
                    out_next.last       = 1'b1;
                    out_next.carrier_ok = carrier_reg;
                    state_next          = S_IDLE;
                    case (cur_reg.op)
                        OP_BEACON:
                        begin
                            rx_time_next = cur_reg.now_ms;
                            rx_seen_next = 1'b1;
                            if (found_reg)
                            begin
                                heard_we        = 1'b1;
                                wr_idx          = found_idx_reg;
                                out_next.status = ST_REFRESHED;
                                out_next.slot   = found_slot_x[SLOT_FIELD_W-1:0];
                            end
                            else if (!free_found_reg || (CMP_W'(used_reg) >= limit_x))
                            begin
                                out_next.status = ST_FULL;
                            end
                            else
                            begin
                                addr_we                  = 1'b1;
                                heard_we                 = 1'b1;
                                rev_we                   = 1'b1;
                                wr_idx                   = free_idx_reg;
                                valid_next[free_idx_reg] = 1'b1;
                                out_next.status          = ST_ADDED;
                                out_next.slot            = free_slot_x[SLOT_FIELD_W-1:0];
                            end
                        end
                        OP_DATA:
                        begin
                            if (found_reg)
                            begin
                                heard_we      = 1'b1;
                                wr_idx        = found_idx_reg;
                                rx_time_next  = cur_reg.now_ms;
                                rx_seen_next  = 1'b1;
                                out_next.slot = found_slot_x[SLOT_FIELD_W-1:0];
                                out_next.status =
                                    (cur_reg.frame_length > cfg.max_frame_len) ?
                                    ST_OVERSIZE : ST_ACCEPTED;
                            end
                            else
                            begin
                                out_next.status = ST_UNKNOWN;
                            end
                        end
                        OP_ECHO:
                        begin
                            echo_time_next  = cur_reg.now_ms;
                            echo_seen_next  = 1'b1;
                            out_next.status = ST_ECHO;
                        end
                        default:
                        begin
                            out_next.status          = ST_TICK;
                            out_next.expired_count   = expired_x[EXP_FIELD_W-1:0];
                            out_next.carrier_changed = changed_reg;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rd_cnt_reg     <= '0;
            ev_v_reg       <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            used_reg       <= '0;
            expired_reg    <= '0;
            changed_reg    <= 1'b0;
            valid_reg      <= '0;
            echo_time_reg  <= '0;
            echo_seen_reg  <= 1'b0;
            rx_time_reg    <= '0;
            rx_seen_reg    <= 1'b0;
            carrier_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_cnt_reg     <= rd_cnt_next;
            ev_v_reg       <= ev_v_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            used_reg       <= used_next;
            expired_reg    <= expired_next;
            changed_reg    <= changed_next;
            valid_reg      <= valid_next;
            echo_time_reg  <= echo_time_next;
            echo_seen_reg  <= echo_seen_next;
            rx_time_reg    <= rx_time_next;
            rx_seen_reg    <= rx_seen_next;
            carrier_reg    <= carrier_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        ev_idx_reg    <= ev_idx_next;
        found_idx_reg <= found_idx_next;
        free_idx_reg  <= free_idx_next;
        out_reg       <= out_next;
    end

    // Table memories: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (addr_we)
        begin
            addr_mem[wr_idx] <= {cur_reg.addr_high, cur_reg.addr_low};
        end
        if (heard_we)
        begin
            heard_mem[wr_idx] <= cur_reg.now_ms;
        end
        if (rev_we)
        begin
            rev_mem[wr_idx] <= cur_reg.now_ms;
        end
        if (rd_en)
        begin
            rd_addr_reg  <= addr_mem[rd_idx];
            rd_heard_reg <= heard_mem[rd_idx];
            rd_rev_reg   <= rev_mem[rd_idx];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/neighbor_table_with_aging_unit.sv =====
// ----------------------------------------------------------------------------
// Neighbour table with aging
// Peer table keyed by IPv6 address with beacon learning, frame checks,
// periodic aging, reverse-beacon requests and carrier detection.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  s_axis    in         tvalid/tready          tdata: addresses, length, time; tuser: op
//  m_axis    out        tvalid/tready          tdata: slot, peer, counts; tuser: status
//  cfg       in         cfg_we (no wait)       cfg_index, cfg_data
//
//  After the queue, an echo goes straight to its result; a beacon or data frame
//  walks the table one slot a cycle, and a tick updates the carrier first and
//  then walks. Every item also waits while the result register is full, and a
//  tick holds its walk while a reverse result waits for the result register.
//  rst_n clears valid bits, carrier, echo and receive history and registers.
//  A two-entry queue keeps the input side taking transactions during stalls.
// ----------------------------------------------------------------------------
`default_nettype none

`include "neighbor_table_with_aging_unit_macros.svh"

module neighbor_table_with_aging_unit
    import nta_pkg::*;
#(
    parameter int unsigned TABLE_SLOTS = 8
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Input stream
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // addr_high[63:0], addr_low[127:64], frame_length[143:128], now_ms[175:144]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // operation[1:0]
    input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
    // Result stream
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // slot[2:0], peer_high[66:3], peer_low[130:67], expired_count[134:131],
    // carrier_ok[135], carrier_changed[136], zero pad[143:137]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // status[3:0]
    output logic [OUT_TUSER_W-1:0]      m_axis_tuser,
    output logic                        m_axis_tlast,
    // Configuration writes
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t  cfg_reg, cfg_next;
    logic  q_valid;
    logic  q_pop;
    item_t q_item;
    res_t  res;

    // Register file: indexes beyond the map are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_PEER_LIMIT:   cfg_next.peer_limit          = cfg_data[LIMIT_W-1:0];
                CFG_EXPIRY:       cfg_next.expiry_ms           = cfg_data[TIME_W-1:0];
                CFG_REVERSE:      cfg_next.reverse_interval_ms = cfg_data[TIME_W-1:0];
                CFG_ECHO_TIMEOUT: cfg_next.echo_timeout_ms     = cfg_data[TIME_W-1:0];
                CFG_LOOPBACK:     cfg_next.loopback_ok         = cfg_data[0];
                CFG_MAX_FRAME:    cfg_next.max_frame_len       = cfg_data[FLEN_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.peer_limit          <= RST_PEER_LIMIT;
            cfg_reg.expiry_ms           <= RST_EXPIRY;
            cfg_reg.reverse_interval_ms <= RST_REVERSE;
            cfg_reg.echo_timeout_ms     <= RST_ECHO_TIMEOUT;
            cfg_reg.loopback_ok         <= RST_LOOPBACK;
            cfg_reg.max_frame_len       <= RST_MAX_FRAME;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: accept, classify, queue
    nta_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_item        (q_item)
    );

    // Back end: table walk, update and result register
    nta_back #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    // Pack the result transaction
    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, res.carrier_changed, res.carrier_ok,
                           res.expired_count, res.peer_low, res.peer_high, res.slot};
    assign m_axis_tuser = res.status;
    assign m_axis_tlast = res.last;

    // Back end only takes an item the queue holds
    `NTA_ASSERT_HOLDS(a_pop_nonempty, clk, rst_n, q_pop, q_valid, "pop from empty queue")
    // One item at a time: a pop is never followed straight by another
    `NTA_ASSERT_NEXT(a_pop_spacing, clk, rst_n, q_pop, !q_pop, "back-to-back pop")
    // Reverse requests are never the closing result of a tick
    `NTA_ASSERT_HOLDS(a_reverse_not_last, clk, rst_n,
        m_axis_tvalid && (res.status == ST_REVERSE), !res.last, "reverse marked last")
    // Carrier change is only reported on tick completion
    `NTA_ASSERT_HOLDS(a_changed_on_tick, clk, rst_n,
        m_axis_tvalid && res.carrier_changed, res.status == ST_TICK, "stray carrier change")

endmodule

`default_nettype wire

// ===== test/neighbor_table_with_aging_unit_checker.sv =====
// ----------------------------------------------------------------------------
// Neighbour table result checker
// Watches the input, result and configuration channels, keeps its own copy of
// the peer table, timers and carrier state, and compares every result
// transaction field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module neighbor_table_with_aging_unit_checker
    import nta_pkg::*;
#(
    parameter int unsigned TABLE_SLOTS = 8
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    input  wire logic                   s_axis_tready,
    // addr_high[63:0], addr_low[127:64], frame_length[143:128], now_ms[175:144]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // operation[1:0]
    input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
    input  wire logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // slot[2:0], peer_high[66:3], peer_low[130:67], expired_count[134:131],
    // carrier_ok[135], carrier_changed[136], zero pad[143:137]
    input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // status[3:0]
    input  wire logic [OUT_TUSER_W-1:0] m_axis_tuser,
    input  wire logic                   m_axis_tlast,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output int                          fail_count,
    output int                          results_due
);

    logic [LIMIT_W-1:0] peer_limit_r;
    logic [TIME_W-1:0]  expiry_r;
    logic [TIME_W-1:0]  reverse_r;
    logic [TIME_W-1:0]  echo_timeout_r;
    logic               loopback_r;
    logic [FLEN_W-1:0]  max_frame_r;

    logic               peer_valid  [TABLE_SLOTS];
    logic [ADDR_W-1:0]  peer_hi     [TABLE_SLOTS];
    logic [ADDR_W-1:0]  peer_lo     [TABLE_SLOTS];
    logic [TIME_W-1:0]  heard_at    [TABLE_SLOTS];
    logic [TIME_W-1:0]  reversed_at [TABLE_SLOTS];
    logic [TIME_W-1:0]  echo_at;
    logic [TIME_W-1:0]  rx_at;
    logic               echo_heard;
    logic               rx_heard;
    logic               carrier;

    res_t               outcome_q [$];
    res_t               oldest;

    task automatic report_mismatch(input string what, input logic [63:0] seen,
                                   input logic [63:0] want);
        fail_count++;
        $display("mismatch on %0s: got %0h, expected %0h at %0t", what, seen, want, $time);
    endtask

    function automatic res_t outcome(input logic [STATUS_W-1:0] status, input int slot,
                                     input logic [ADDR_W-1:0] ph, input logic [ADDR_W-1:0] pl,
                                     input int expired, input logic changed,
                                     input logic is_last);
        res_t r;
        r.status          = status;
        r.slot            = slot[SLOT_FIELD_W-1:0];
        r.peer_high       = ph;
        r.peer_low        = pl;
        r.expired_count   = expired[EXP_FIELD_W-1:0];
        r.carrier_ok      = carrier;
        r.carrier_changed = changed;
        r.last            = is_last;
        return r;
    endfunction

    function automatic int find_peer(input logic [ADDR_W-1:0] hi, input logic [ADDR_W-1:0] lo);
        int i;
        for (i = 0; i < TABLE_SLOTS; i++)
            if (peer_valid[i] && peer_hi[i] == hi && peer_lo[i] == lo)
                return i;
        return -1;
    endfunction

    // Advance the table by one input transaction and queue what it produces
    task automatic step_table(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] hi,
                              input logic [ADDR_W-1:0] lo, input logic [FLEN_W-1:0] flen,
                              input logic [TIME_W-1:0] now);
        int                i;
        int                hit;
        int                free_slot;
        int                used;
        int                lim;
        int                expired;
        logic [TIME_W-1:0] age;
        logic              echo_ok;
        logic              rx_ok;
        logic              ok;
        logic              changed;
        case (op)
            OP_BEACON:
            begin
                hit      = find_peer(hi, lo);
                rx_at    = now;
                rx_heard = 1'b1;
                if (hit >= 0)
                begin
                    heard_at[hit] = now;
                    outcome_q.push_back(outcome(ST_REFRESHED, hit, '0, '0, 0, 1'b0, 1'b1));
                end
                else
                begin
                    lim       = (peer_limit_r == '0) ? 1 : int'(peer_limit_r);
                    used      = 0;
                    free_slot = -1;
                    for (i = 0; i < TABLE_SLOTS; i++)
                    begin
                        if (peer_valid[i])
                            used++;
                        else if (free_slot < 0)
                            free_slot = i;
                    end
                    if (used >= lim || free_slot < 0)
                        outcome_q.push_back(outcome(ST_FULL, 0, '0, '0, 0, 1'b0, 1'b1));
                    else
                    begin
                        peer_valid[free_slot]  = 1'b1;
                        peer_hi[free_slot]     = hi;
                        peer_lo[free_slot]     = lo;
                        heard_at[free_slot]    = now;
                        reversed_at[free_slot] = now;
                        outcome_q.push_back(outcome(ST_ADDED, free_slot, '0, '0, 0, 1'b0,
                                                    1'b1));
                    end
                end
            end
            OP_DATA:
            begin
                hit = find_peer(hi, lo);
                if (hit < 0)
                    outcome_q.push_back(outcome(ST_UNKNOWN, 0, '0, '0, 0, 1'b0, 1'b1));
                else
                begin
                    heard_at[hit] = now;
                    rx_at         = now;
                    rx_heard      = 1'b1;
                    outcome_q.push_back(outcome((flen > max_frame_r) ? ST_OVERSIZE : ST_ACCEPTED,
                                                hit, '0, '0, 0, 1'b0, 1'b1));
                end
            end
            OP_ECHO:
            begin
                echo_at    = now;
                echo_heard = 1'b1;
                outcome_q.push_back(outcome(ST_ECHO, 0, '0, '0, 0, 1'b0, 1'b1));
            end
            OP_TICK:
            begin
                age     = now - echo_at;
                echo_ok = echo_heard && (age <= echo_timeout_r);
                age     = now - rx_at;
                rx_ok   = rx_heard && (age <= echo_timeout_r);
                ok      = loopback_r ? (echo_ok || rx_ok) : rx_ok;
                changed = (ok != carrier);
                carrier = ok;
                expired = 0;
                for (i = 0; i < TABLE_SLOTS; i++)
                begin
                    if (peer_valid[i])
                    begin
                        age = now - heard_at[i];
                        if (age > expiry_r)
                        begin
                            peer_valid[i] = 1'b0;
                            expired++;
                        end
                        else
                        begin
                            age = now - reversed_at[i];
                            if (age >= reverse_r)
                            begin
                                reversed_at[i] = now;
                                outcome_q.push_back(outcome(ST_REVERSE, i, peer_hi[i],
                                                            peer_lo[i], 0, 1'b0, 1'b0));
                            end
                        end
                    end
                end
                outcome_q.push_back(outcome(ST_TICK, 0, '0, '0, expired, changed, 1'b1));
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peer_limit_r   = RST_PEER_LIMIT;
            expiry_r       = RST_EXPIRY;
            reverse_r      = RST_REVERSE;
            echo_timeout_r = RST_ECHO_TIMEOUT;
            loopback_r     = RST_LOOPBACK;
            max_frame_r    = RST_MAX_FRAME;
            for (int i = 0; i < TABLE_SLOTS; i++)
                peer_valid[i] = 1'b0;
            echo_at     = '0;
            rx_at       = '0;
            echo_heard  = 1'b0;
            rx_heard    = 1'b0;
            carrier     = 1'b0;
            outcome_q.delete();
            fail_count  = 0;
            results_due = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PEER_LIMIT:   peer_limit_r   = cfg_data[LIMIT_W-1:0];
                    CFG_EXPIRY:       expiry_r       = cfg_data[TIME_W-1:0];
                    CFG_REVERSE:      reverse_r      = cfg_data[TIME_W-1:0];
                    CFG_ECHO_TIMEOUT: echo_timeout_r = cfg_data[TIME_W-1:0];
                    CFG_LOOPBACK:     loopback_r     = cfg_data[0];
                    CFG_MAX_FRAME:    max_frame_r    = cfg_data[FLEN_W-1:0];
                    default:          ;
                endcase
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                if (outcome_q.size() == 0)
                    report_mismatch("result with none expected, status",
                                    64'(m_axis_tuser), 64'd0);
                else
                begin
                    oldest = outcome_q.pop_front();
                    if (m_axis_tuser != oldest.status)
                        report_mismatch("status", 64'(m_axis_tuser), 64'(oldest.status));
                    if (m_axis_tdata[2:0] != oldest.slot)
                        report_mismatch("slot", 64'(m_axis_tdata[2:0]), 64'(oldest.slot));
                    if (m_axis_tdata[66:3] != oldest.peer_high)
                        report_mismatch("peer_high", m_axis_tdata[66:3], oldest.peer_high);
                    if (m_axis_tdata[130:67] != oldest.peer_low)
                        report_mismatch("peer_low", m_axis_tdata[130:67], oldest.peer_low);
                    if (m_axis_tdata[134:131] != oldest.expired_count)
                        report_mismatch("expired_count", 64'(m_axis_tdata[134:131]),
                                        64'(oldest.expired_count));
                    if (m_axis_tdata[135] != oldest.carrier_ok)
                        report_mismatch("carrier_ok", 64'(m_axis_tdata[135]),
                                        64'(oldest.carrier_ok));
                    if (m_axis_tdata[136] != oldest.carrier_changed)
                        report_mismatch("carrier_changed", 64'(m_axis_tdata[136]),
                                        64'(oldest.carrier_changed));
                    if (m_axis_tlast != oldest.last)
                        report_mismatch("last", 64'(m_axis_tlast), 64'(oldest.last));
                end
            end

            if (s_axis_tvalid && s_axis_tready)
                step_table(s_axis_tuser[OP_W-1:0], s_axis_tdata[63:0], s_axis_tdata[127:64],
                           s_axis_tdata[143:128], s_axis_tdata[175:144]);

            results_due = outcome_q.size();
        end
    end

endmodule

// ===== test/neighbor_table_with_aging_unit_test.sv =====
// ----------------------------------------------------------------------------
// Neighbour table with aging testbench
// Drives beacons, data frames, own echoes and ticks into the table under a
// series of register settings, with random gaps on the input side and random
// back-pressure on the result side; a checker beside the block predicts and
// compares every result and the top gives the verdict.
// ----------------------------------------------------------------------------
module neighbor_table_with_aging_unit_test;
    import nta_pkg::*;

    localparam int SLOTS        = 8;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int POOL_SIZE    = 12;
    localparam int PHASE_ITEMS  = 50;
    localparam int PHASES       = 6;
    localparam int END_SETTLE   = 40;

    // Indexes past the register map; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [IN_TUSER_W-1:0]  s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int                     fail_count;
    int                     results_due;
    int                     cycle_count = 0;
    logic                   calm = 1'b0;
    int                     stall_left = 0;

    // Addresses reused across the run so that beacons refresh and frames hit
    logic [ADDR_W-1:0]      pool_hi [POOL_SIZE];
    logic [ADDR_W-1:0]      pool_lo [POOL_SIZE];
    logic [TIME_W-1:0]      clock_ms;
    logic [FLEN_W-1:0]      frame_cap;

    neighbor_table_with_aging_unit #(
        .TABLE_SLOTS(SLOTS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    neighbor_table_with_aging_unit_checker #(
        .TABLE_SLOTS(SLOTS)
    ) table_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .results_due  (results_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case the block hangs or a result never turns up
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Gap length: mostly none or short, now and then a long one; none when calm
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Result side back-pressure: hold tready low for a random number of cycles
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_axis_tready = 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready = 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Fill the bits a register does not keep with noise
    function automatic logic [CFG_DATA_W-1:0] scramble(input logic [CFG_DATA_W-1:0] value,
                                                       input logic [CFG_DATA_W-1:0] keep);
        return (value & keep) | ($urandom & ~keep);
    endfunction

    // One input transaction; entered and left at a falling edge, tvalid left high
    task automatic send_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] hi,
                             input logic [ADDR_W-1:0] lo, input logic [FLEN_W-1:0] flen,
                             input logic [TIME_W-1:0] now);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  = {now, flen, lo, hi};
        s_axis_tuser  = op;
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Drop tvalid and hold the input side until every predicted result is in
    task automatic settle();
        s_axis_tvalid = 1'b0;
        while (results_due != 0)
            @(negedge clk);
    endtask

    // Register write; the caller lowers cfg_we after the last one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_index = idx;
        cfg_data  = data;
        cfg_we    = 1'b1;
        @(negedge clk);
    endtask

    task automatic load_settings(input logic [CFG_DATA_W-1:0] limit,
                                 input logic [CFG_DATA_W-1:0] expiry,
                                 input logic [CFG_DATA_W-1:0] reverse,
                                 input logic [CFG_DATA_W-1:0] echo_to,
                                 input logic [CFG_DATA_W-1:0] loopback,
                                 input logic [CFG_DATA_W-1:0] max_len);
        write_reg(CFG_PEER_LIMIT, scramble(limit, 32'h0000_000F));
        write_reg(CFG_EXPIRY, expiry);
        write_reg(CFG_REVERSE, reverse);
        write_reg(CFG_ECHO_TIMEOUT, echo_to);
        write_reg(CFG_LOOPBACK, scramble(loopback, 32'h0000_0001));
        write_reg(CFG_MAX_FRAME, scramble(max_len, 32'h0000_FFFF));
        cfg_we    = 1'b0;
        frame_cap = max_len[FLEN_W-1:0];
    endtask

    // Random transaction: mostly pool addresses so the table sees refreshes,
    // hits and full conditions; the rest stray addresses as noise
    task automatic random_item();
        int                r;
        int                k;
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] lo;
        logic [FLEN_W-1:0] flen;
        r = $urandom_range(0, 99);
        if (r < 35)
            op = OP_BEACON;
        else if (r < 65)
            op = OP_DATA;
        else if (r < 75)
            op = OP_ECHO;
        else
            op = OP_TICK;
        k = $urandom_range(0, POOL_SIZE - 1);
        if ($urandom_range(0, 99) < 85)
        begin
            hi = pool_hi[k];
            lo = pool_lo[k];
        end
        else
        begin
            hi = {$urandom, $urandom};
            lo = {$urandom, $urandom};
        end
        // Frame length: anywhere, hugging the oversize boundary, or typical
        r = $urandom_range(0, 9);
        if (r < 3)
            flen = 16'($urandom);
        else if (r < 6)
            flen = frame_cap + 16'($urandom_range(0, 2)) - 16'd1;
        else
            flen = 16'($urandom_range(0, 1500));
        // Time: small steps, larger steps that age peers out, rare jumps
        r = $urandom_range(0, 99);
        if (r < 70)
            clock_ms = clock_ms + $urandom_range(0, 1500);
        else if (r < 95)
            clock_ms = clock_ms + $urandom_range(1500, 30000);
        else
            clock_ms = $urandom;
        send_item(op, hi, lo, flen, clock_ms);
    endtask

    initial
    begin
        int                i;
        int                phase;
        int                n;
        logic [ADDR_W-1:0] fill_hi;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        frame_cap     = RST_MAX_FRAME;
        clock_ms      = $urandom;

        // Pool: all zeros, all ones, and pairs that share one half of the address
        for (i = 0; i < POOL_SIZE; i++)
        begin
            pool_hi[i] = {$urandom, $urandom};
            pool_lo[i] = {$urandom, $urandom};
        end
        pool_hi[0] = '0;
        pool_lo[0] = '0;
        pool_hi[1] = '1;
        pool_lo[1] = '1;
        pool_hi[3] = pool_hi[2];
        pool_lo[5] = pool_lo[4];

        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed part under the reset settings
        // Empty table and nothing heard: carrier stays lost
        send_item(OP_TICK, '0, '0, '0, 32'd0);
        // Frame from a peer never seen
        send_item(OP_DATA, '1, '1, 16'd10, 32'd50);
        send_item(OP_BEACON, '0, '0, '0, 32'd100);
        send_item(OP_BEACON, '1, '1, '1, 32'd200);
        send_item(OP_BEACON, '0, '0, '0, 32'd300);
        // High half matches a peer, low half does not
        send_item(OP_DATA, '0, 64'd1, 16'd10, 32'd350);
        // Length exactly at the limit, one past it, and the largest
        send_item(OP_DATA, '0, '0, 16'd500, 32'd400);
        send_item(OP_DATA, '1, '1, 16'd501, 32'd410);
        send_item(OP_DATA, '1, '1, '1, 32'd420);
        send_item(OP_ECHO, '1, '1, '1, '1);
        // Both peers due for a reverse beacon, carrier comes up
        send_item(OP_TICK, '0, '0, '0, 32'd6000);
        // Both peers stale, carrier lost again
        send_item(OP_TICK, '1, '1, '1, 32'd30000);

        // Fill every slot just before the time wraps, then one more
        for (i = 0; i < SLOTS; i++)
        begin
            fill_hi = {8'(i), 56'h5A_5A5A_5A5A_5A5A};
            send_item(OP_BEACON, fill_hi, ~fill_hi, '0, 32'hFFFF_FF00 + i);
        end
        send_item(OP_BEACON, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, '0,
                  32'hFFFF_FF08);
        // Ages measured across the wrap stay small
        send_item(OP_TICK, '0, '0, '0, 32'h0000_0100);

        // Zero expiry, zero peer limit, loopback off, writes past the map
        settle();
        write_reg(CFG_EXPIRY, 32'd0);
        write_reg(CFG_PEER_LIMIT, 32'hFFFF_FFF0);
        write_reg(CFG_SPARE_A, $urandom);
        write_reg(CFG_SPARE_B, $urandom);
        write_reg(CFG_LOOPBACK, 32'hFFFF_FFFE);
        cfg_we = 1'b0;

        // Every peer expires at once
        send_item(OP_TICK, '0, '0, '0, 32'h0000_0101);
        // A zero limit still admits one peer
        send_item(OP_BEACON, pool_hi[2], pool_lo[2], '0, 32'h0000_0200);
        send_item(OP_BEACON, pool_hi[3], pool_lo[3], '0, 32'h0000_0210);

        // Random part, one register setting per phase
        for (phase = 0; phase < PHASES; phase++)
        begin
            settle();
            case (phase)
                0: load_settings(32'd8, 32'd22000, 32'd5200, 32'd6500, 32'd1, 32'd500);
                // Limit above the table size, nothing ever expires, zero timeouts
                1: load_settings(32'd15, '1, 32'd0, 32'd0, 32'd0, 32'd0);
                2: load_settings(32'd3, 32'd3000, 32'd1000, 32'd2000, 32'd1, 32'hFFFF);
                3: load_settings(32'd1, $urandom, '1, '1, 32'd0, $urandom);
                default:
                    load_settings($urandom_range(0, 15), $urandom_range(0, 40000),
                                  $urandom_range(0, 12000), $urandom_range(0, 12000),
                                  $urandom_range(0, 1), $urandom_range(0, 2000));
            endcase
            // Last phase runs without random gaps or back-pressure on either side
            calm = (phase == PHASES - 1);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 39) == 0)
                    settle();
                random_item();
            end
        end

        settle();
        calm = 1'b0;
        repeat (END_SETTLE) @(negedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
